// File: rtl/core/assert_macros.svh
// Assertion macros shared by the operand fetch RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  `ASSERT_AT(lbl, clk, rstn, !(cond))

`endif

// File: rtl/core/ofam_pkg.sv
// Shared constants and word types of the operand fetch unit.
// Depends on nothing.
package ofam_pkg;

  localparam int ADDR_BITS = 16;
  localparam int WORD_BITS = 16;
  localparam int BYTE_BITS = 8;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  localparam logic [1:0] KIND_UNARY = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_BYTE  = 2'd2;
  localparam logic [1:0] KIND_WORD  = 2'd3;

  localparam logic [2:0] MODE_I   = 3'd0;
  localparam logic [2:0] MODE_D   = 3'd1;
  localparam logic [2:0] MODE_N   = 3'd2;
  localparam logic [2:0] MODE_S   = 3'd3;
  localparam logic [2:0] MODE_SF  = 3'd4;
  localparam logic [2:0] MODE_X   = 3'd5;
  localparam logic [2:0] MODE_SX  = 3'd6;
  localparam logic [2:0] MODE_SFX = 3'd7;

  typedef struct packed {
    logic                 action;
    logic [15:0]          mem_address;
    logic [BYTE_BITS-1:0] mem_data;
    logic [1:0]           operand_kind;
    logic [2:0]           addr_mode;
    logic [WORD_BITS-1:0] operand_spec;
    logic [WORD_BITS-1:0] stack_pointer;
    logic [WORD_BITS-1:0] index_reg;
  } in_word_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] operand_value;
  } out_word_t;

endpackage

// File: rtl/core/ofam_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on ofam_pkg.
interface ofam_in_if;
  import ofam_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ofam_out_if;
  import ofam_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/ofam_ram.sv
// Single-port synchronous RAM with registered read data.
// Depends on nothing.
module ofam_ram #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/operand_fetch_addressing_modes_unit.sv
// Operand fetch unit: addressing mode evaluation over a byte-wide main memory.
// Depends on ofam_pkg, ofam_if, ofam_ram and assert_macros.svh.
//
// Channels: in_i carries one word per item; action selects a memory byte
// write or an operand evaluation. out_o carries one result word per
// evaluation; a write gives no result.
// A write is accepted and stored while the unit stays idle. An evaluation
// of a unary operand, an immediate or a non-indirect store goes straight
// to the done state; a direct load reads its operand byte or bytes; an
// indirect mode first reads the two pointer bytes, then a load reads its operand.
// The single byte port of the memory reads one byte per cycle with
// registered read data; the unit works one item at a time.
// The output register holds a finished result while the next item is
// accepted; when it is still full at the end of an evaluation the unit
// holds the result until the receiver takes the waiting word.
// Reset clears control state and empties the output register; memory
// contents are undefined until written.
module operand_fetch_addressing_modes_unit (
  input logic clk_i,
  input logic rst_ni,
  ofam_in_if.sink    in_i,
  ofam_out_if.source out_o
);
  import ofam_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_P0,
    ST_RD_P1,
    ST_RD_P2,
    ST_RD_O0,
    ST_RD_O1,
    ST_RD_O2,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [1:0]           kind_q;
  logic [2:0]           mode_q;
  logic [WORD_BITS-1:0] x_q;
  logic [WORD_BITS-1:0] addr_q;
  logic [BYTE_BITS-1:0] hi_q;
  logic [WORD_BITS-1:0] val_q;
  logic                 out_valid_q;
  out_word_t            out_q;

  logic                 in_acc;
  logic                 slot_free;
  logic                 ram_we;
  logic                 ram_re;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [BYTE_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] sum_sp;
  logic [WORD_BITS-1:0] ea_direct;
  logic [WORD_BITS-1:0] ptr_addr;
  logic [WORD_BITS-1:0] ea_indirect;
  logic [WORD_BITS-1:0] imm_val;
  logic                 is_indirect;
  in_word_t             iw;

  assign iw        = in_i.data;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;

  assign sum_sp      = iw.operand_spec + iw.stack_pointer;
  assign ptr_addr    = (iw.addr_mode == MODE_N) ? iw.operand_spec : sum_sp;
  assign is_indirect = (iw.addr_mode == MODE_N) || (iw.addr_mode == MODE_SF) ||
                       (iw.addr_mode == MODE_SFX);

  always_comb begin
    case (iw.addr_mode)
      MODE_D:  ea_direct = iw.operand_spec;
      MODE_S:  ea_direct = sum_sp;
      MODE_X:  ea_direct = iw.operand_spec + iw.index_reg;
      MODE_SX: ea_direct = sum_sp + iw.index_reg;
      default: ea_direct = iw.operand_spec;
    endcase
  end

  always_comb begin
    case (iw.operand_kind)
      KIND_BYTE: imm_val = {{(WORD_BITS-BYTE_BITS){1'b0}}, iw.operand_spec[BYTE_BITS-1:0]};
      KIND_WORD: imm_val = iw.operand_spec;
      default:   imm_val = '0;
    endcase
  end

  assign ea_indirect = {hi_q, ram_rdata} + ((mode_q == MODE_SFX) ? x_q : '0);

  assign ram_we   = in_acc && (iw.action == ACT_WRITE);
  assign ram_re   = (state_q == ST_RD_P0) || (state_q == ST_RD_P1) ||
                    (state_q == ST_RD_O0) || (state_q == ST_RD_O1);
  assign ram_addr = ram_we ? iw.mem_address[ADDR_BITS-1:0] : addr_q[ADDR_BITS-1:0];

  ofam_ram #(
    .AW (ADDR_BITS),
    .DW (BYTE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (iw.mem_data),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_DONE) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (iw.action == ACT_EVAL)) begin
            kind_q <= iw.operand_kind;
            mode_q <= iw.addr_mode;
            x_q    <= iw.index_reg;
            if ((iw.operand_kind == KIND_UNARY) || (iw.addr_mode == MODE_I)) begin
              val_q   <= imm_val;
              state_q <= ST_DONE;
            end else if (is_indirect) begin
              addr_q  <= ptr_addr;
              state_q <= ST_RD_P0;
            end else if (iw.operand_kind == KIND_STORE) begin
              val_q   <= ea_direct;
              state_q <= ST_DONE;
            end else begin
              addr_q  <= ea_direct;
              state_q <= ST_RD_O0;
            end
          end
        end
        ST_RD_P0: begin
          addr_q  <= addr_q + WORD_BITS'(1);
          state_q <= ST_RD_P1;
        end
        ST_RD_P1: begin
          hi_q    <= ram_rdata;
          state_q <= ST_RD_P2;
        end
        ST_RD_P2: begin
          if (kind_q == KIND_STORE) begin
            val_q   <= ea_indirect;
            state_q <= ST_DONE;
          end else begin
            addr_q  <= ea_indirect;
            state_q <= ST_RD_O0;
          end
        end
        ST_RD_O0: begin
          addr_q  <= addr_q + WORD_BITS'(1);
          state_q <= (kind_q == KIND_BYTE) ? ST_RD_O2 : ST_RD_O1;
        end
        ST_RD_O1: begin
          hi_q    <= ram_rdata;
          state_q <= ST_RD_O2;
        end
        ST_RD_O2: begin
          if (kind_q == KIND_BYTE) begin
            val_q <= {{(WORD_BITS-BYTE_BITS){1'b0}}, ram_rdata};
          end else begin
            val_q <= {hi_q, ram_rdata};
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            out_q.operand_value <= val_q;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `ASSERT_AT(a_write_one_cycle, clk_i, rst_ni,
             (in_acc && (iw.action == ACT_WRITE)) |=> (state_q == ST_IDLE))
  `ASSERT_NEVER(a_no_rw_overlap, clk_i, rst_ni, ram_we && ram_re)
  `ASSERT_AT(a_unary_zero, clk_i, rst_ni,
             ((state_q == ST_DONE) && (kind_q == KIND_UNARY)) |-> (val_q == '0))
  `ASSERT_AT(a_done_loads, clk_i, rst_ni,
             ((state_q == ST_DONE) && slot_free) |=> (out_valid_q && (state_q == ST_IDLE)))

endmodule

// File: test/operand_fetch_addressing_modes_unit_test.sv
// Testbench for operand_fetch_addressing_modes_unit: directed rows with given results,
// then random words checked against a byte-memory predictor of eight addressing modes.
// Depends on ofam_pkg, ofam_if and the unit's RTL.
module operand_fetch_addressing_modes_unit_test;
  import ofam_pkg::*;

  localparam int ITEM_TARGET = 1400;
  localparam int IDLE_LIMIT  = 500;
  localparam int DRAIN_WAIT  = 20;

  typedef struct {
    in_word_t    w;
    bit          typed;
    logic [15:0] value;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ofam_in_if  in_ch ();
  ofam_out_if out_ch ();

  operand_fetch_addressing_modes_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #2 clk_i = ~clk_i;

  logic [7:0]  operand_memory [0:65535];
  bit          byte_written   [0:65535];
  logic [15:0] pending_operands [$];
  stim_row_t   stim_rows [$];
  int          mismatch_count;
  int          words_sent;
  int          idle_cycles;
  int          stall_left;
  int          hold;
  bit          in_calm;
  bit          out_calm;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 15));
      1: return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] mem_word(input logic [15:0] a);
    logic [15:0] a_next;
    a_next = a + 16'd1;
    return {operand_memory[a], operand_memory[a_next]};
  endfunction

  function automatic logic [15:0] effective_addr(input logic [2:0] mode,
                                                 input logic [15:0] spec, sp, x);
    logic [15:0] ea;
    case (mode)
      MODE_D:   ea = spec;
      MODE_N:   ea = mem_word(spec);
      MODE_S:   ea = spec + sp;
      MODE_SF:  ea = mem_word(spec + sp);
      MODE_X:   ea = spec + x;
      MODE_SX:  ea = spec + sp + x;
      MODE_SFX: ea = mem_word(spec + sp) + x;
      default:  ea = '0;
    endcase
    return ea;
  endfunction

  function automatic logic [15:0] predict_operand(input in_word_t w);
    logic [15:0] ea;
    if (w.operand_kind == KIND_UNARY) return '0;
    if (w.addr_mode == MODE_I) begin
      case (w.operand_kind)
        KIND_STORE: return '0;
        KIND_BYTE:  return {8'h00, w.operand_spec[7:0]};
        default:    return w.operand_spec;
      endcase
    end
    ea = effective_addr(w.addr_mode, w.operand_spec, w.stack_pointer, w.index_reg);
    case (w.operand_kind)
      KIND_STORE: return ea;
      KIND_BYTE:  return {8'h00, operand_memory[ea]};
      default:    return mem_word(ea);
    endcase
  endfunction

  function automatic in_word_t mk_write(input logic [15:0] a, input logic [7:0] d);
    in_word_t w;
    w.action        = ACT_WRITE;
    w.mem_address   = a;
    w.mem_data      = d;
    w.operand_kind  = 2'($urandom);
    w.addr_mode     = 3'($urandom);
    w.operand_spec  = 16'($urandom);
    w.stack_pointer = 16'($urandom);
    w.index_reg     = 16'($urandom);
    return w;
  endfunction

  function automatic in_word_t mk_eval(input logic [1:0] kind, input logic [2:0] mode,
                                       input logic [15:0] spec, sp, x);
    in_word_t w;
    w.action        = ACT_EVAL;
    w.mem_address   = 16'($urandom);
    w.mem_data      = 8'($urandom);
    w.operand_kind  = kind;
    w.addr_mode     = mode;
    w.operand_spec  = spec;
    w.stack_pointer = sp;
    w.index_reg     = x;
    return w;
  endfunction

  function automatic void add_row(input in_word_t w, input bit typed, input logic [15:0] value);
    stim_row_t r;
    r.w     = w;
    r.typed = typed;
    r.value = value;
    stim_rows.push_back(r);
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input logic [15:0] value);
    int gap;
    in_ch.data  <= w;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    words_sent++;
    if (w.action == ACT_WRITE) begin
      operand_memory[w.mem_address] = w.mem_data;
      byte_written[w.mem_address]   = 1'b1;
    end else begin
      pending_operands.push_back(typed ? value : predict_operand(w));
    end
    gap = draw_gap(in_calm);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic fill_byte(input logic [15:0] a);
    if (!byte_written[a]) send_word(mk_write(a, 8'($urandom)), 1'b0, '0);
  endtask

  // Make sure every byte the evaluation will read has been written, then send it.
  task automatic send_prepared_eval();
    in_word_t    w;
    logic [15:0] ptr_at;
    logic [15:0] ea;
    w = mk_eval(2'($urandom), 3'($urandom), rand_word(), rand_word(), rand_word());
    if (w.operand_kind != KIND_UNARY && w.addr_mode != MODE_I) begin
      if (w.addr_mode == MODE_N || w.addr_mode == MODE_SF || w.addr_mode == MODE_SFX) begin
        ptr_at = (w.addr_mode == MODE_N) ? w.operand_spec : w.operand_spec + w.stack_pointer;
        if ($urandom_range(0, 1)) begin
          send_word(mk_write(ptr_at, 8'($urandom)), 1'b0, '0);
          send_word(mk_write(ptr_at + 16'd1, 8'($urandom)), 1'b0, '0);
        end else begin
          fill_byte(ptr_at);
          fill_byte(ptr_at + 16'd1);
        end
      end
      ea = effective_addr(w.addr_mode, w.operand_spec, w.stack_pointer, w.index_reg);
      if (w.operand_kind != KIND_STORE) fill_byte(ea);
      if (w.operand_kind == KIND_WORD) fill_byte(ea + 16'd1);
    end
    send_word(w, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (pending_operands.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected",
                                  out_ch.data.operand_value));
      end else if (out_ch.data.operand_value !== pending_operands[0]) begin
        report_mismatch($sformatf("operand_value %h, expected %h",
                                  out_ch.data.operand_value, pending_operands[0]));
        void'(pending_operands.pop_front());
      end else begin
        void'(pending_operands.pop_front());
      end
      if ($urandom_range(0, 63) == 0) out_calm = ~out_calm;
      hold = draw_gap(out_calm);
      if (hold != 0) out_ch.ready <= 1'b0;
      stall_left <= hold;
    end else if (!out_ch.ready) begin
      if (stall_left <= 1) out_ch.ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    mismatch_count = 0;
    words_sent   = 0;
    in_calm      = 1'b0;

    add_row('1 & mk_write(16'hFFFF, 8'hAB) | {1'b0, 16'h0, 8'h0, {2'b11, 3'b111, {48{1'b1}}}}
            , 1'b0, '0);
    add_row(mk_write(16'h0000, 8'hCD), 1'b0, '0);
    add_row({ACT_EVAL, 16'hFFFF, 8'hFF, KIND_UNARY, MODE_SFX, 16'hFFFF, 16'hFFFF, 16'hFFFF},
            1'b1, 16'h0000);
    add_row(mk_eval(KIND_STORE, MODE_I,   16'hFFFF, 16'h0000, 16'h0000), 1'b1, 16'h0000);
    add_row(mk_eval(KIND_BYTE,  MODE_I,   16'hFFFF, 16'h0000, 16'h0000), 1'b1, 16'h00FF);
    add_row(mk_eval(KIND_WORD,  MODE_I,   16'hFFFF, 16'h0000, 16'h0000), 1'b1, 16'hFFFF);
    add_row(mk_eval(KIND_WORD,  MODE_I,   16'h0000, 16'hFFFF, 16'hFFFF), 1'b1, 16'h0000);
    add_row(mk_eval(KIND_STORE, MODE_D,   16'hFFFF, 16'h0000, 16'h0000), 1'b1, 16'hFFFF);
    add_row(mk_eval(KIND_STORE, MODE_S,   16'hFFFF, 16'h0002, 16'h0000), 1'b1, 16'h0001);
    add_row(mk_eval(KIND_STORE, MODE_X,   16'h8000, 16'h0000, 16'h8000), 1'b1, 16'h0000);
    add_row(mk_eval(KIND_STORE, MODE_SX,  16'hFFFF, 16'hFFFF, 16'h0002), 1'b1, 16'h0000);
    add_row(mk_eval(KIND_WORD,  MODE_D,   16'hFFFF, 16'h0000, 16'h0000), 1'b1, 16'hABCD);
    add_row(mk_eval(KIND_BYTE,  MODE_D,   16'h0000, 16'h0000, 16'h0000), 1'b1, 16'h00CD);
    add_row(mk_write(16'hABCD, 8'h12), 1'b0, '0);
    add_row(mk_write(16'hABCE, 8'h34), 1'b0, '0);
    add_row(mk_eval(KIND_STORE, MODE_N,   16'hFFFF, 16'h0000, 16'h0000), 1'b1, 16'hABCD);
    add_row(mk_eval(KIND_WORD,  MODE_N,   16'hFFFF, 16'h0000, 16'h0000), 1'b1, 16'h1234);
    add_row(mk_eval(KIND_STORE, MODE_SF,  16'hFFFE, 16'h0001, 16'h0000), 1'b1, 16'hABCD);
    add_row(mk_eval(KIND_BYTE,  MODE_SF,  16'hFFFE, 16'h0001, 16'h0000), 1'b1, 16'h0012);
    add_row(mk_eval(KIND_STORE, MODE_SFX, 16'hFFFE, 16'h0001, 16'h5433), 1'b1, 16'h0000);
    add_row(mk_eval(KIND_BYTE,  MODE_SFX, 16'h0000, 16'hFFFF, 16'h0001), 1'b1, 16'h0034);
    add_row(mk_write(16'h8000, 8'hFF), 1'b0, '0);
    add_row(mk_eval(KIND_BYTE,  MODE_X,   16'h7FFF, 16'h0000, 16'h0001), 1'b1, 16'h00FF);
    add_row(mk_eval(KIND_WORD,  MODE_SX,  16'hABCB, 16'h0001, 16'h0001), 1'b1, 16'h1234);
    add_row(mk_eval(KIND_BYTE,  MODE_S,   16'hABCC, 16'h0001, 16'h0000), 1'b1, 16'h0012);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) send_word(stim_rows[i].w, stim_rows[i].typed, stim_rows[i].value);

    while (words_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 63) == 0) in_calm = ~in_calm;
      if ($urandom_range(0, 99) < 15)
        send_word(mk_write(rand_word(), 8'($urandom)), 1'b0, '0);
      else
        send_prepared_eval();
    end
    in_ch.valid <= 1'b0;

    while (pending_operands.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_operands.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_operands.size()));

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
